[rtl/core/etp_pkg.sv]
// ----------------------------------------------------------------------------
// Escape-time pixel unit package
// Shared widths, register indexes, multiplier operations, command and status
// structs, and the saturating arithmetic helpers of the Q5.58 datapath.
// ----------------------------------------------------------------------------
package etp_pkg;

  localparam int unsigned DATA_W     = 64;
  localparam int unsigned COORD_W    = 62;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned SHIFT_W    = 6;
  localparam int unsigned FRAC_BITS  = 58;
  localparam int unsigned WIDTH_DEF  = 128;
  localparam int unsigned HEIGHT_DEF = 64;

  // Squared-magnitude escape bound, 4.0 in Q5.58.
  localparam logic signed [DATA_W-1:0] FOUR_Q   = 64'sh1000_0000_0000_0000;
  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Viewport reset values: real axis -2.0 to 4.0, imaginary axis -1.0 to 1.0.
  localparam logic [COORD_W-1:0] REAL_MIN_RST = 62'h3800_0000_0000_0000;
  localparam logic [COORD_W-1:0] REAL_MAX_RST = 62'h1000_0000_0000_0000;
  localparam logic [COORD_W-1:0] IMAG_MIN_RST = 62'h3C00_0000_0000_0000;
  localparam logic [COORD_W-1:0] IMAG_MAX_RST = 62'h0400_0000_0000_0000;
  localparam logic [LIMIT_W-1:0] LIMIT_RST    = 16'd1000;

  localparam logic [SHIFT_W-1:0] SH_SQUARE = SHIFT_W'(FRAC_BITS);
  localparam logic [SHIFT_W-1:0] SH_CROSS  = SHIFT_W'(FRAC_BITS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REAL_MIN,
    CFG_REAL_MAX,
    CFG_IMAG_MIN,
    CFG_IMAG_MAX,
    CFG_ITER_LIMIT
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_MAP_RE,
    OP_MAP_IM,
    OP_XY,
    OP_XX,
    OP_YY
  } mul_op_e;

  typedef struct packed {
    logic    load_pix;
    logic    mul_start;
    mul_op_e mul_op;
    logic    load_cre;
    logic    load_cim;
    logic    load_diff;
    logic    load_xy;
    logic    load_xx;
    logic    load_yy;
    logic    out_load;
  } etp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic cont;
  } etp_sts_t;

  function automatic logic signed [DATA_W-1:0] sat_add(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? DATA_MIN : DATA_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_neg(input logic signed [DATA_W-1:0] a);
    if (a == DATA_MIN) begin
      return DATA_MAX;
    end
    return -a;
  endfunction

  function automatic logic signed [DATA_W-1:0] coord_sext(input logic [COORD_W-1:0] v);
    return {{(DATA_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

endpackage

[rtl/core/etp_mul.sv]
// ----------------------------------------------------------------------------
// Iterative signed multiplier with shift and saturation
// Forms a full 64x64 signed product from four 33x33 partial products, then
// shifts it right arithmetically and saturates it to 64 bits.
// ----------------------------------------------------------------------------
module etp_mul
  import etp_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [DATA_W-1:0]  a_i,
  input  logic signed [DATA_W-1:0]  b_i,
  input  logic        [SHIFT_W-1:0] shift_i,
  output logic                      done_o,
  output logic signed [DATA_W-1:0]  res_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MUL,
    PH_DRAIN,
    PH_SHIFT
  } phase_e;

  localparam int unsigned HALF_W = DATA_W / 2;
  localparam int unsigned PP_W   = 2 * (HALF_W + 1);
  localparam int unsigned ACC_W  = 2 * DATA_W;

  phase_e                    phase_q;
  logic [1:0]                cnt_q;
  logic                      done_q;
  logic signed [DATA_W-1:0]  a_q;
  logic signed [DATA_W-1:0]  b_q;
  logic [SHIFT_W-1:0]        sh_q;
  logic signed [PP_W-1:0]    pp_q;
  logic [1:0]                pp_idx_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [DATA_W-1:0]  res_q;

  logic signed [HALF_W:0]    op_a;
  logic signed [HALF_W:0]    op_b;
  logic signed [PP_W-1:0]    pp_d;
  logic signed [ACC_W-1:0]   pp_ext;
  logic signed [ACC_W-1:0]   addend;
  logic                      acc_en;
  logic signed [ACC_W-1:0]   sh_full;
  logic                      fits;
  logic signed [DATA_W-1:0]  res_d;

  // Low halves enter as unsigned, high halves keep the sign.
  always_comb begin
    unique case (cnt_q)
      2'd0: begin
        op_a = {1'b0, a_q[HALF_W-1:0]};
        op_b = {1'b0, b_q[HALF_W-1:0]};
      end
      2'd1: begin
        op_a = {1'b0, a_q[HALF_W-1:0]};
        op_b = {b_q[DATA_W-1], b_q[DATA_W-1:HALF_W]};
      end
      2'd2: begin
        op_a = {a_q[DATA_W-1], a_q[DATA_W-1:HALF_W]};
        op_b = {1'b0, b_q[HALF_W-1:0]};
      end
      default: begin
        op_a = {a_q[DATA_W-1], a_q[DATA_W-1:HALF_W]};
        op_b = {b_q[DATA_W-1], b_q[DATA_W-1:HALF_W]};
      end
    endcase
  end

  assign pp_d   = op_a * op_b;
  assign pp_ext = {{(ACC_W-PP_W){pp_q[PP_W-1]}}, pp_q};

  always_comb begin
    unique case (pp_idx_q)
      2'd0:    addend = pp_ext;
      2'd3:    addend = pp_ext <<< DATA_W;
      default: addend = pp_ext <<< HALF_W;
    endcase
  end

  assign acc_en = ((phase_q == PH_MUL) && (cnt_q != 2'd0)) || (phase_q == PH_DRAIN);

  assign sh_full = acc_q >>> sh_q;
  assign fits    = (&sh_full[ACC_W-1:DATA_W-1]) || !(|sh_full[ACC_W-1:DATA_W-1]);
  assign res_d   = fits ? sh_full[DATA_W-1:0] : (acc_q[ACC_W-1] ? DATA_MIN : DATA_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= 2'd0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (phase_q)
        PH_IDLE: begin
          if (start_i) begin
            phase_q <= PH_MUL;
            cnt_q   <= 2'd0;
          end
        end
        PH_MUL: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            phase_q <= PH_DRAIN;
          end
        end
        PH_DRAIN: begin
          phase_q <= PH_SHIFT;
        end
        PH_SHIFT: begin
          phase_q <= PH_IDLE;
          done_q  <= 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      sh_q  <= shift_i;
      acc_q <= '0;
    end else if (acc_en) begin
      acc_q <= acc_q + addend;
    end
    if (phase_q == PH_MUL) begin
      pp_q     <= pp_d;
      pp_idx_q <= cnt_q;
    end
    if (phase_q == PH_SHIFT) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (phase_q == PH_IDLE))
    else $error("multiplier started while busy");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##7 done_q)
    else $error("multiplier result not ready after fixed latency");
`endif

endmodule

[rtl/core/etp_datapath.sv]
// ----------------------------------------------------------------------------
// Escape-time datapath
// Viewport registers, pixel mapping, z iteration registers, escape test and
// result register, built around one shared iterative multiplier.
// ----------------------------------------------------------------------------
module etp_datapath
  import etp_pkg::*;
#(
  parameter int unsigned WIDTH  = WIDTH_DEF,
  parameter int unsigned HEIGHT = HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [COORD_W-1:0]             cfg_wdata_i,
  input  logic [$clog2(WIDTH)-1:0]       pixel_col_i,
  input  logic [$clog2(HEIGHT)-1:0]      pixel_row_i,
  input  etp_cmd_t                       cmd_i,
  output etp_sts_t                       sts_o,
  output logic                           pixel_on_o,
  output logic [LIMIT_W-1:0]             escape_count_o
);

  localparam int unsigned COL_W = $clog2(WIDTH);
  localparam int unsigned ROW_W = $clog2(HEIGHT);
  // The map divides by the largest power of two not above the frame size.
  localparam logic [SHIFT_W-1:0] COL_SHIFT = SHIFT_W'($clog2(WIDTH + 1) - 1);
  localparam logic [SHIFT_W-1:0] ROW_SHIFT = SHIFT_W'($clog2(HEIGHT + 1) - 1);

  logic [COORD_W-1:0]       real_min_q;
  logic [COORD_W-1:0]       real_max_q;
  logic [COORD_W-1:0]       imag_min_q;
  logic [COORD_W-1:0]       imag_max_q;
  logic [LIMIT_W-1:0]       limit_q;

  logic [COL_W-1:0]         pix_col_q;
  logic [ROW_W-1:0]         pix_row_q;
  logic signed [DATA_W-1:0] cre_q;
  logic signed [DATA_W-1:0] cim_q;
  logic signed [DATA_W-1:0] x_q;
  logic signed [DATA_W-1:0] y_q;
  logic signed [DATA_W-1:0] xx_q;
  logic signed [DATA_W-1:0] yy_q;
  logic signed [DATA_W-1:0] diff_q;
  logic signed [DATA_W-1:0] mag_q;
  logic [LIMIT_W-1:0]       cnt_q;
  logic                     pixel_on_q;
  logic [LIMIT_W-1:0]       escape_count_q;

  logic signed [DATA_W-1:0] span_re;
  logic signed [DATA_W-1:0] span_im;
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic [SHIFT_W-1:0]       mul_sh;
  logic                     mul_done;
  logic signed [DATA_W-1:0] mul_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_min_q <= REAL_MIN_RST;
      real_max_q <= REAL_MAX_RST;
      imag_min_q <= IMAG_MIN_RST;
      imag_max_q <= IMAG_MAX_RST;
      limit_q    <= LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REAL_MIN:   real_min_q <= cfg_wdata_i;
        CFG_REAL_MAX:   real_max_q <= cfg_wdata_i;
        CFG_IMAG_MIN:   imag_min_q <= cfg_wdata_i;
        CFG_IMAG_MAX:   imag_max_q <= cfg_wdata_i;
        CFG_ITER_LIMIT: limit_q    <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Both edges fit in 62 bits, so the span fits in 64 without saturation.
  assign span_re = coord_sext(real_max_q) - coord_sext(real_min_q);
  assign span_im = coord_sext(imag_max_q) - coord_sext(imag_min_q);

  always_comb begin
    unique case (cmd_i.mul_op)
      OP_MAP_RE: begin
        mul_a  = {{(DATA_W-COL_W){1'b0}}, pix_col_q};
        mul_b  = span_re;
        mul_sh = COL_SHIFT;
      end
      OP_MAP_IM: begin
        mul_a  = {{(DATA_W-ROW_W){1'b0}}, pix_row_q};
        mul_b  = span_im;
        mul_sh = ROW_SHIFT;
      end
      OP_XY: begin
        mul_a  = x_q;
        mul_b  = y_q;
        mul_sh = SH_CROSS;
      end
      OP_YY: begin
        mul_a  = y_q;
        mul_b  = y_q;
        mul_sh = SH_SQUARE;
      end
      default: begin
        mul_a  = x_q;
        mul_b  = x_q;
        mul_sh = SH_SQUARE;
      end
    endcase
  end

  etp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .shift_i (mul_sh),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // The squares of the new z are cached, so they serve both the escape test
  // and the next iteration.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pix) begin
      pix_col_q <= pixel_col_i;
      pix_row_q <= pixel_row_i;
    end
    if (cmd_i.load_cre) begin
      cre_q <= sat_add(coord_sext(real_min_q), mul_res);
    end
    if (cmd_i.load_cim) begin
      cim_q <= sat_add(coord_sext(imag_min_q), mul_res);
      x_q   <= '0;
      y_q   <= '0;
      xx_q  <= '0;
      yy_q  <= '0;
      mag_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.load_diff) begin
      diff_q <= sat_add(xx_q, sat_neg(yy_q));
    end
    if (cmd_i.load_xy) begin
      x_q <= sat_add(diff_q, cre_q);
      y_q <= sat_add(mul_res, cim_q);
    end
    if (cmd_i.load_xx) begin
      xx_q <= mul_res;
    end
    if (cmd_i.load_yy) begin
      yy_q  <= mul_res;
      mag_q <= sat_add(xx_q, mul_res);
      cnt_q <= cnt_q + LIMIT_W'(1);
    end
    if (cmd_i.out_load) begin
      pixel_on_q     <= (mag_q < FOUR_Q);
      escape_count_q <= cnt_q;
    end
  end

  assign sts_o.mul_done = mul_done;
  assign sts_o.cont     = (mag_q <= FOUR_Q) && (cnt_q < limit_q);

  assign pixel_on_o     = pixel_on_q;
  assign escape_count_o = escape_count_q;

endmodule

[rtl/core/etp_ctrl.sv]
// ----------------------------------------------------------------------------
// Escape-time controller
// Sequences the pixel mapping, the iteration loop and the result hand-off.
// ----------------------------------------------------------------------------
module etp_ctrl
  import etp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  etp_sts_t sts_i,
  output etp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP_RE,
    S_MAP_IM,
    S_CHECK,
    S_XY,
    S_XX,
    S_YY,
    S_FINISH
  } state_e;

  state_e  state_q;
  logic    mul_start_q;
  mul_op_e mul_op_q;
  logic    out_valid_q;
  logic    out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mul_start_q <= 1'b0;
      mul_op_q    <= OP_MAP_RE;
      out_valid_q <= 1'b0;
    end else begin
      mul_start_q <= 1'b0;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q     <= S_MAP_RE;
            mul_start_q <= 1'b1;
            mul_op_q    <= OP_MAP_RE;
          end
        end
        S_MAP_RE: begin
          if (sts_i.mul_done) begin
            state_q     <= S_MAP_IM;
            mul_start_q <= 1'b1;
            mul_op_q    <= OP_MAP_IM;
          end
        end
        S_MAP_IM: begin
          if (sts_i.mul_done) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (sts_i.cont) begin
            state_q     <= S_XY;
            mul_start_q <= 1'b1;
            mul_op_q    <= OP_XY;
          end else begin
            state_q <= S_FINISH;
          end
        end
        S_XY: begin
          if (sts_i.mul_done) begin
            state_q     <= S_XX;
            mul_start_q <= 1'b1;
            mul_op_q    <= OP_XX;
          end
        end
        S_XX: begin
          if (sts_i.mul_done) begin
            state_q     <= S_YY;
            mul_start_q <= 1'b1;
            mul_op_q    <= OP_YY;
          end
        end
        S_YY: begin
          if (sts_i.mul_done) begin
            state_q <= S_CHECK;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
          end
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.load_pix  = in_valid_i && (state_q == S_IDLE);
    cmd_o.mul_start = mul_start_q;
    cmd_o.mul_op    = mul_op_q;
    cmd_o.load_cre  = (state_q == S_MAP_RE) && sts_i.mul_done;
    cmd_o.load_cim  = (state_q == S_MAP_IM) && sts_i.mul_done;
    cmd_o.load_diff = (state_q == S_CHECK);
    cmd_o.load_xy   = (state_q == S_XY) && sts_i.mul_done;
    cmd_o.load_xx   = (state_q == S_XX) && sts_i.mul_done;
    cmd_o.load_yy   = (state_q == S_YY) && sts_i.mul_done;
    cmd_o.out_load  = (state_q == S_FINISH) && out_free;
  end

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.mul_done |-> (state_q == S_MAP_RE || state_q == S_MAP_IM ||
                        state_q == S_XY || state_q == S_XX || state_q == S_YY))
    else $error("multiplier result arrived outside a wait state");
`endif

endmodule

[rtl/core/mandelbrot_escape_time_pixel_unit.sv]
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel unit
// Maps one pixel into the configured complex viewport and iterates
// z = z^2 + c in saturating signed Q5.58 until escape or the iteration limit.
//
//   Channel   Direction  Handshake                 Payload
//   in        sink       in_valid_i / in_ready_o   pixel_col_i, pixel_row_i
//   out       source     out_valid_o / out_ready_i pixel_on_o, escape_count_o
//   cfg       sink       cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// The time from a pixel's input beat to out_valid_o, when the output does not
// stall, grows with the number of iterations performed (at most the iteration
// limit) and is set by the single shared multiplier: each 64x64 product is
// built from four 33x33 partial products plus drain and shift steps, and one
// iteration needs three products (x*y, x^2, y^2) and one escape-test state.
// Reset clears the controller and restores the default viewport
// (-2.0..4.0 by -1.0..1.0) and an iteration limit of 1000.
// One pixel is in flight at a time; a new pixel beat is taken while the
// previous result still waits in the output register, and a stalled output
// only holds the unit once the next result is finished.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_unit
  import etp_pkg::*;
#(
  parameter int unsigned WIDTH  = WIDTH_DEF,
  parameter int unsigned HEIGHT = HEIGHT_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,

  // Viewport and iteration limit registers.
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [COORD_W-1:0]        cfg_wdata_i,

  // Pixel coordinate beats.
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [$clog2(WIDTH)-1:0]  pixel_col_i,
  input  logic [$clog2(HEIGHT)-1:0] pixel_row_i,

  // Result beats.
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      pixel_on_o,
  output logic [LIMIT_W-1:0]        escape_count_o
);

  // The controller and the datapath talk only through these two structs.
  etp_cmd_t cmd;
  etp_sts_t sts;

  etp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  etp_datapath #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .pixel_col_i    (pixel_col_i),
    .pixel_row_i    (pixel_row_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .pixel_on_o     (pixel_on_o),
    .escape_count_o (escape_count_o)
  );

endmodule

[dv/mandelbrot_escape_time_pixel_unit_test.sv]
// ----------------------------------------------------------------------------
// Escape-time pixel unit testbench
// Drives pixel beats into the unit, takes the escape count and lit flag of each
// pixel from a typed result or its own model of the fixed-point iteration, and
// checks every result beat in order. A short table of directed rows comes first,
// followed by randomized blocks that each load a fresh viewport and iteration
// limit and then run under one of several idling patterns on both channels.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_unit_test;
  import etp_pkg::*;

  localparam int unsigned COLS  = WIDTH_DEF;
  localparam int unsigned ROWS  = HEIGHT_DEF;
  localparam int unsigned COL_W = $clog2(COLS);
  localparam int unsigned ROW_W = $clog2(ROWS);

  // Register indexes above the last real register; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = CFG_IDX_W'(CFG_ITER_LIMIT) + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = '1;

  // Viewport corner values used by the directed rows, in Q3.58, and one thousandth in Q5.58.
  localparam logic [COORD_W-1:0] COORD_MOST_NEG   = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] COORD_MOST_POS   = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] Q_TWO_AND_HALF   = 62'h0A00_0000_0000_0000;
  localparam logic [COORD_W-1:0] Q_SEVEN_AND_HALF = 62'h1E00_0000_0000_0000;
  localparam logic signed [DATA_W-1:0] MILLI_Q    = (64'sd1 <<< FRAC_BITS) / 1000;

  localparam int BLOCKS          = 20;
  localparam int BLOCK_ITEMS     = 30;
  localparam int HOLD_BLOCK      = 6;
  localparam int HOLD_CYCLES     = 3000;
  localparam int TAIL_CYCLES     = 60;
  localparam int WATCHDOG_CYCLES = 200000;
  localparam int MAX_PRINTED     = 40;
  localparam int DIRECTED_ROWS   = 24;

  typedef struct packed {
    logic               lit;
    logic [LIMIT_W-1:0] steps;
  } escape_result_t;

  typedef enum logic {ROW_PIX, ROW_CFG} row_kind_e;

  // One row of the directed table: either a register write or a pixel beat.
  // A pixel row with a typed result is checked against that value; the others
  // go through the predictor.
  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [COORD_W-1:0]   data;
    logic [COL_W-1:0]     px_col;
    logic [ROW_W-1:0]     px_row;
    logic                 typed;
    escape_result_t       want;
  } row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [COORD_W-1:0]   cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [COL_W-1:0]     pixel_col_i = '0;
  logic [ROW_W-1:0]     pixel_row_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 pixel_on_o;
  logic [LIMIT_W-1:0]   escape_count_o;

  // Shadow copy of the viewport and iteration limit, updated with each write.
  logic [COORD_W-1:0] view_re_lo = REAL_MIN_RST;
  logic [COORD_W-1:0] view_re_hi = REAL_MAX_RST;
  logic [COORD_W-1:0] view_im_lo = IMAG_MIN_RST;
  logic [COORD_W-1:0] view_im_hi = IMAG_MAX_RST;
  logic [LIMIT_W-1:0] iter_cap   = LIMIT_RST;

  escape_result_t pending_escapes[$];
  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  row_t directed_plan [DIRECTED_ROWS] = '{
    // Default viewport straight out of reset. The far corner leaves the radius
    // on the first step; the center row near the origin runs the full 1000.
    '{ROW_PIX, '0, '0, 7'd127, 6'd63, 1'b1, '{1'b0, 16'd1}},
    '{ROW_PIX, '0, '0, 7'd0,   6'd0,  1'b0, '0},
    '{ROW_PIX, '0, '0, 7'd42,  6'd32, 1'b0, '0},
    // A zero limit runs no step at all: z stays at the origin and is lit.
    '{ROW_CFG, CFG_ITER_LIMIT, COORD_W'(0), '0, '0, 1'b0, '0},
    '{ROW_PIX, '0, '0, 7'd64,  6'd32, 1'b1, '{1'b1, 16'd0}},
    '{ROW_PIX, '0, '0, 7'd127, 6'd63, 1'b1, '{1'b1, 16'd0}},
    '{ROW_CFG, CFG_ITER_LIMIT, COORD_W'(1), '0, '0, 1'b0, '0},
    '{ROW_PIX, '0, '0, 7'd64,  6'd32, 1'b0, '0},
    // Widest possible viewport, imaginary axis reversed. The corners overflow
    // the squares and exercise the saturation of the magnitude.
    '{ROW_CFG, CFG_REAL_MIN,   COORD_MOST_NEG, '0, '0, 1'b0, '0},
    '{ROW_CFG, CFG_REAL_MAX,   COORD_MOST_POS, '0, '0, 1'b0, '0},
    '{ROW_CFG, CFG_IMAG_MIN,   COORD_MOST_POS, '0, '0, 1'b0, '0},
    '{ROW_CFG, CFG_IMAG_MAX,   COORD_MOST_NEG, '0, '0, 1'b0, '0},
    '{ROW_CFG, CFG_ITER_LIMIT, COORD_W'(3),    '0, '0, 1'b0, '0},
    '{ROW_PIX, '0, '0, 7'd0,   6'd0,  1'b0, '0},
    '{ROW_PIX, '0, '0, 7'd127, 6'd63, 1'b0, '0},
    '{ROW_PIX, '0, '0, 7'd64,  6'd32, 1'b0, '0},
    // Real axis entirely beyond 2.0, so the largest limit still costs one step.
    '{ROW_CFG, CFG_REAL_MIN,   Q_TWO_AND_HALF,      '0, '0, 1'b0, '0},
    '{ROW_CFG, CFG_REAL_MAX,   Q_SEVEN_AND_HALF,    '0, '0, 1'b0, '0},
    '{ROW_CFG, CFG_ITER_LIMIT, COORD_W'(16'hFFFF), '0, '0, 1'b0, '0},
    '{ROW_PIX, '0, '0, 7'd127, 6'd0,  1'b0, '0},
    '{ROW_PIX, '0, '0, 7'd0,   6'd63, 1'b0, '0},
    // Writes to the unused indexes must leave every register alone.
    '{ROW_CFG, CFG_IDX_SPARE_LO, '0,             '0, '0, 1'b0, '0},
    '{ROW_CFG, CFG_IDX_SPARE_HI, COORD_MOST_POS, '0, '0, 1'b0, '0},
    '{ROW_PIX, '0, '0, 7'd1,   6'd1,  1'b0, '0}
  };

  mandelbrot_escape_time_pixel_unit #(
    .WIDTH (COLS),
    .HEIGHT(ROWS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_col_i   (pixel_col_i),
    .pixel_row_i   (pixel_row_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_on_o    (pixel_on_o),
    .escape_count_o(escape_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point model of one pixel.
  // ---------------------------------------------------------------------------

  // Sum clamped to the signed 64-bit range.
  function automatic logic signed [DATA_W-1:0] clamp_add(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic signed [DATA_W:0] sum;
    sum = a + b;
    if (sum > DATA_MAX) begin
      return DATA_MAX;
    end
    if (sum < DATA_MIN) begin
      return DATA_MIN;
    end
    return sum[DATA_W-1:0];
  endfunction

  // Full 128-bit product, arithmetic shift right (rounds toward minus
  // infinity), then clamped back to 64 bits.
  function automatic logic signed [DATA_W-1:0] fixed_mul(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b,
    input int                       sh
  );
    logic signed [2*DATA_W-1:0] prod;
    prod = a * b;
    prod = prod >>> sh;
    if (prod > DATA_MAX) begin
      return DATA_MAX;
    end
    if (prod < DATA_MIN) begin
      return DATA_MIN;
    end
    return prod[DATA_W-1:0];
  endfunction

  // Linear map of a pixel index onto one axis of the viewport. The frame size
  // is a power of two, so the division by it is a shift by its log.
  function automatic logic signed [DATA_W-1:0] axis_point(
    input int unsigned        pix,
    input logic [COORD_W-1:0] lo,
    input logic [COORD_W-1:0] hi,
    input int                 sh
  );
    logic signed [DATA_W-1:0] lo_s;
    logic signed [DATA_W-1:0] hi_s;
    lo_s = {{(DATA_W-COORD_W){lo[COORD_W-1]}}, lo};
    hi_s = {{(DATA_W-COORD_W){hi[COORD_W-1]}}, hi};
    return clamp_add(lo_s, fixed_mul(DATA_W'(pix), hi_s - lo_s, sh));
  endfunction

  // Iterates z = z^2 + c from the origin while |z|^2 stays at or below 4.0
  // and the limit is not reached. The cross term 2xy folds the doubling into
  // a shift one bit shorter.
  function automatic escape_result_t predict_escape(
    input logic [COL_W-1:0] col,
    input logic [ROW_W-1:0] row
  );
    logic signed [DATA_W-1:0] c_re;
    logic signed [DATA_W-1:0] c_im;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] x_next;
    logic signed [DATA_W-1:0] mag;
    int unsigned steps;
    escape_result_t res;
    c_re  = axis_point(col, view_re_lo, view_re_hi, COL_W);
    c_im  = axis_point(row, view_im_lo, view_im_hi, ROW_W);
    x     = '0;
    y     = '0;
    mag   = '0;
    steps = 0;
    while (mag <= FOUR_Q && steps < iter_cap) begin
      x_next = clamp_add(clamp_add(fixed_mul(x, x, FRAC_BITS), -fixed_mul(y, y, FRAC_BITS)),
                         c_re);
      y      = clamp_add(fixed_mul(x, y, FRAC_BITS - 1), c_im);
      x      = x_next;
      mag    = clamp_add(fixed_mul(x, x, FRAC_BITS), fixed_mul(y, y, FRAC_BITS));
      steps++;
    end
    res.lit   = (mag < FOUR_Q);
    res.steps = steps[LIMIT_W-1:0];
    return res;
  endfunction

  // Random coordinate between two bounds given in thousandths, with random
  // low-order bits so the fraction is not round.
  function automatic logic [COORD_W-1:0] rand_coord(input int lo_m, input int hi_m);
    logic signed [DATA_W-1:0] q;
    q = DATA_W'(lo_m + int'($urandom_range(0, hi_m - lo_m))) * MILLI_Q
        + DATA_W'($urandom());
    return q[COORD_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers.
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what);
    if (mismatch_count < MAX_PRINTED) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  // Writes one register on the next edge and mirrors it in the shadow copy.
  // The write enable stays high; the caller lowers it after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_REAL_MIN:   view_re_lo = data;
      CFG_REAL_MAX:   view_re_hi = data;
      CFG_IMAG_MIN:   view_im_lo = data;
      CFG_IMAG_MAX:   view_im_hi = data;
      CFG_ITER_LIMIT: iter_cap   = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // Offers one pixel beat, possibly after a random gap, and returns at the
  // edge that accepts it. Valid is left high so a back-to-back beat can follow.
  task automatic offer_pixel(
    input logic [COL_W-1:0] col,
    input logic [ROW_W-1:0] row,
    input logic             typed,
    input escape_result_t   want
  );
    escape_result_t due;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do begin
        @(posedge clk_i);
      end while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i  <= 1'b1;
    pixel_col_i <= col;
    pixel_row_i <= row;
    due = typed ? want : predict_escape(col, row);
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    pending_escapes.push_back(due);
  endtask

  // Stops offering pixels and waits until every expected result has come back.
  // One result per pixel means the unit is idle once the list is empty.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_escapes.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pattern, long hold-off, and the in-order check.
  // ---------------------------------------------------------------------------

  // The hold-off is counted here, so the sender keeps offering beats while the
  // output is blocked and the unit has to fill up and refuse input.
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Signals are read right after the edge, before any nonblocking update of
  // that edge lands, so they hold the values the unit saw at the edge.
  always @(posedge clk_i) begin : result_check
    escape_result_t head;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_escapes.size() == 0) begin
        flag_mismatch($sformatf("result beat with no pixel pending (on %0b, count %0d)",
                                pixel_on_o, escape_count_o));
      end else begin
        head = pending_escapes.pop_front();
        if (pixel_on_o !== head.lit) begin
          flag_mismatch($sformatf("pixel_on %0b, expected %0b", pixel_on_o, head.lit));
        end
        if (escape_count_o !== head.steps) begin
          flag_mismatch($sformatf("escape_count %0d, expected %0d",
                                  escape_count_o, head.steps));
        end
      end
    end
  end

  // Any cycle that moves a beat on either channel clears the count. The limit
  // covers a full-length pixel at the default limit several times over.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [COORD_W-1:0] re_lo;
    logic [COORD_W-1:0] re_hi;
    logic [COORD_W-1:0] im_lo;
    logic [COORD_W-1:0] im_hi;
    logic [COORD_W-1:0] swap;
    logic [LIMIT_W-1:0] cap;
    int pick;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Register writes only happen once the unit has drained.
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        if (!cfg_we_i) begin
          wait_for_results();
        end
        write_reg(directed_plan[i].reg_idx, directed_plan[i].data);
      end else begin
        if (cfg_we_i) begin
          cfg_we_i <= 1'b0;
        end
        offer_pixel(directed_plan[i].px_col, directed_plan[i].px_row,
                    directed_plan[i].typed, directed_plan[i].want);
      end
    end

    // Random blocks. Each one drains the unit, loads a new setting and then
    // streams pixels under one idling pattern.
    for (int blk = 0; blk < BLOCKS; blk++) begin
      wait_for_results();
      pick = (blk == HOLD_BLOCK) ? 0 : $urandom_range(0, 9);
      if (pick < 6) begin
        // Window around the set, where escape counts spread widely. Limits
        // stay small to keep the run short; now and then the real axis runs
        // backwards.
        re_lo = rand_coord(-2500, -500);
        re_hi = re_lo + rand_coord(10, 3000);
        im_lo = rand_coord(-1500, 500);
        im_hi = im_lo + rand_coord(10, 2000);
        if ($urandom_range(0, 7) == 0) begin
          swap  = re_lo;
          re_lo = re_hi;
          re_hi = swap;
        end
        cap = LIMIT_W'($urandom_range(1, 40));
      end else if (pick < 8) begin
        // Arbitrary corners anywhere in the coordinate range.
        re_lo = COORD_W'({$urandom(), $urandom()});
        re_hi = COORD_W'({$urandom(), $urandom()});
        im_lo = COORD_W'({$urandom(), $urandom()});
        im_hi = COORD_W'({$urandom(), $urandom()});
        cap   = LIMIT_W'($urandom_range(1, 16));
      end else begin
        // Real part always beyond 2.0: every pixel with a nonzero limit escapes on
        // its first step, so any limit, the largest ones included, is cheap.
        re_lo = rand_coord(2100, 7900);
        re_hi = rand_coord(2100, 7900);
        im_lo = COORD_W'({$urandom(), $urandom()});
        im_hi = COORD_W'({$urandom(), $urandom()});
        cap   = LIMIT_W'($urandom_range(0, 65535));
      end
      write_reg(CFG_REAL_MIN, re_lo);
      write_reg(CFG_REAL_MAX, re_hi);
      write_reg(CFG_IMAG_MIN, im_lo);
      write_reg(CFG_IMAG_MAX, im_hi);
      // Bits above the limit field carry junk that the unit must drop.
      write_reg(CFG_ITER_LIMIT, {(COORD_W-LIMIT_W)'({$urandom(), $urandom()}), cap});
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_SPARE_LO, CFG_IDX_SPARE_HI)),
                  COORD_W'({$urandom(), $urandom()}));
      end
      cfg_we_i <= 1'b0;

      case (blk % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 74;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 74;
        end
        default: begin
          send_idle_pct  = 38;
          recv_stall_pct = 38;
        end
      endcase
      if (blk == HOLD_BLOCK) begin
        hold_left = HOLD_CYCLES;
      end

      repeat (BLOCK_ITEMS) begin
        offer_pixel(COL_W'($urandom()), ROW_W'($urandom()), 1'b0, '0);
      end
    end

    // Let the last results come back, then watch a little longer for any
    // beat that should not be there.
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
